@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge out of reset.
`define CPTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define CPTS_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/cpts_pkg.sv @@
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types and constants of the counter priority task scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

    localparam int MAX_TASKS_DEF  = 16;
    localparam int PRIO_BITS_DEF  = 8;

    localparam int ACT_W          = 5;
    localparam int SLOT_W         = 4;
    localparam int PRIO_REQ_W     = 8;

    localparam logic [ACT_W-1:0] ACT_RESET = 5'd2;

    // item kinds
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_SET_PRIO = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [SLOT_W-1:0]     task_index;
        logic [PRIO_REQ_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic              stalled;
        logic              reloaded;
        logic              switched;
        logic [SLOT_W-1:0] running_task;
    } res_t;

endpackage

@@ rtl/cpts_core.sv @@
// ----------------------------------------------------------------------------
// cpts_core
// Counter and priority memories with the tick / schedule / reload sequencer.
// ----------------------------------------------------------------------------
module cpts_core #(
    parameter int MAX_TASKS     = cpts_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = cpts_pkg::PRIO_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [cpts_pkg::ACT_W-1:0] cfg_wdata,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  cpts_pkg::req_t             req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output cpts_pkg::res_t             res
);
    import cpts_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int PB    = PRIORITY_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_SCAN,
        ST_DECIDE,
        ST_RELOAD,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [ACT_W-1:0] act_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [PB-1:0]    best_reg;
    logic [IDX_W-1:0] pick_reg;
    logic             found_reg;
    logic             sw_reg;
    logic             reload_reg;
    logic             stall_reg;

    // memories; an entry whose valid bit is low reads as zero
    logic [PB-1:0]        cnt_mem  [MAX_TASKS];
    logic [PB-1:0]        prio_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] cnt_vld_reg;
    logic [MAX_TASKS-1:0] prio_vld_reg;
    logic [PB-1:0]        cnt_rd_reg;
    logic                 cnt_rd_vld_reg;
    logic [PB-1:0]        prio_rd_reg;
    logic                 prio_rd_vld_reg;

    logic [PB-1:0]    cnt_rd_val;
    logic [PB-1:0]    prio_rd_val;
    logic [6:0]       act_ext;
    logic [CNT_W-1:0] n_slots;
    logic             set_ok;
    logic             issue;

    logic             cnt_re;
    logic [IDX_W-1:0] cnt_ra;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_wa;
    logic [PB-1:0]    cnt_wd;
    logic             cnt_clr;
    logic             prio_we;
    logic [IDX_W-1:0] prio_wa;
    logic [PB-1:0]    prio_wd;
    logic             prio_re;
    logic [IDX_W-1:0] prio_ra;

    assign cnt_rd_val  = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign prio_rd_val = prio_rd_vld_reg ? prio_rd_reg : '0;

    // slot count clamped to 1..MAX_TASKS
    assign act_ext = {2'b00, act_reg};
    always_comb begin
        if (act_reg == '0) begin
            n_slots = CNT_W'(1);
        end else if (act_ext > 7'(MAX_TASKS)) begin
            n_slots = CNT_W'(MAX_TASKS);
        end else begin
            n_slots = CNT_W'(act_ext);
        end
    end

    assign set_ok = (req.task_index != '0) &&
                    ({3'b000, req.task_index} < 7'(MAX_TASKS));
    assign issue  = (idx_reg < n_slots);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.running_task = SLOT_W'(cur_reg);
    assign res.switched     = sw_reg;
    assign res.reloaded     = reload_reg;
    assign res.stalled      = stall_reg;

    // memory port control
    always_comb begin
        cnt_re  = 1'b0;
        cnt_ra  = idx_reg[IDX_W-1:0];
        cnt_we  = 1'b0;
        cnt_wa  = cur_reg;
        cnt_wd  = '0;
        cnt_clr = 1'b0;
        prio_we = 1'b0;
        prio_wa = IDX_W'(req.task_index);
        prio_wd = PB'(req.priority_req);
        prio_re = 1'b0;
        prio_ra = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req.kind == KIND_SET_PRIO) begin
                        prio_we = set_ok;
                        cnt_clr = set_ok;
                    end else begin
                        cnt_re = 1'b1;
                        cnt_ra = cur_reg;
                    end
                end
            end
            ST_CUR: begin
                if (cur_reg != '0 && cnt_rd_val != '0) begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_rd_val - 1'b1;
                end
            end
            ST_SCAN: begin
                cnt_re = issue;
            end
            ST_RELOAD: begin
                prio_re = issue;
                if (pend_reg) begin
                    cnt_we = 1'b1;
                    cnt_wa = pend_idx_reg;
                    cnt_wd = prio_rd_val;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg  <= '0;
            prio_vld_reg <= '0;
        end else begin
            if (cnt_we) begin
                cnt_vld_reg[cnt_wa] <= 1'b1;
            end
            if (cnt_clr) begin
                cnt_vld_reg[prio_wa] <= 1'b0;
            end
            if (prio_we) begin
                prio_vld_reg[prio_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            cnt_rd_reg     <= cnt_mem[cnt_ra];
            cnt_rd_vld_reg <= cnt_vld_reg[cnt_ra];
        end
        if (prio_we) begin
            prio_mem[prio_wa] <= prio_wd;
        end
        if (prio_re) begin
            prio_rd_reg     <= prio_mem[prio_ra];
            prio_rd_vld_reg <= prio_vld_reg[prio_ra];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            act_reg    <= ACT_RESET;
            cur_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            sw_reg     <= 1'b0;
            reload_reg <= 1'b0;
            stall_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                act_reg <= cfg_wdata;
            end
            // a read issued this cycle returns next cycle
            pend_reg <= (state_reg == ST_SCAN || state_reg == ST_RELOAD) && issue;
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        sw_reg     <= 1'b0;
                        reload_reg <= 1'b0;
                        stall_reg  <= 1'b0;
                        state_reg  <= (req.kind == KIND_SET_PRIO) ? ST_DONE : ST_CUR;
                    end
                end
                ST_CUR: begin
                    // idle slot, exhausted, or just hit zero: reschedule
                    if (cur_reg == '0 || cnt_rd_val == '0 || cnt_rd_val == PB'(1)) begin
                        idx_reg   <= '0;
                        best_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        idx_reg      <= idx_reg + 1'b1;
                        pend_idx_reg <= idx_reg[IDX_W-1:0];
                    end else begin
                        state_reg <= ST_DECIDE;
                    end
                    // strict compare keeps the lowest index on a tie
                    if (pend_reg && cnt_rd_val > best_reg) begin
                        best_reg  <= cnt_rd_val;
                        pick_reg  <= pend_idx_reg;
                        found_reg <= 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (found_reg) begin
                        sw_reg    <= (pick_reg != cur_reg);
                        cur_reg   <= pick_reg;
                        state_reg <= ST_DONE;
                    end else if (!reload_reg) begin
                        reload_reg <= 1'b1;
                        idx_reg    <= CNT_W'(1);
                        state_reg  <= ST_RELOAD;
                    end else begin
                        stall_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_RELOAD: begin
                    if (issue) begin
                        idx_reg      <= idx_reg + 1'b1;
                        pend_idx_reg <= idx_reg[IDX_W-1:0];
                    end else begin
                        idx_reg   <= '0;
                        best_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `CPTS_IMPLY(a_pick_range, state_reg == ST_DECIDE && found_reg, CNT_W'(pick_reg) < n_slots, "pick outside active slots")
    `CPTS_IMPLY(a_stall_reload, res_valid && res.stalled, res.reloaded, "stall without reload")
    `CPTS_IMPLY(a_pend_state, pend_reg, state_reg == ST_SCAN || state_reg == ST_RELOAD, "read pending outside scan or reload")
    `CPTS_ASSERT(a_cnt_port, !(cnt_we && cnt_clr), "counter write and clear collide")

endmodule

@@ rtl/counter_priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter based priority scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per handshake. tuser is the kind (0 timer tick,
// 1 set priority); tdata carries task_index and priority_req.
// Output channel m_*: exactly one result item per input item, in order.
// Configuration: cfg_we writes active_tasks from cfg_wdata; write it only
// while the block is idle.
// A set-priority item goes straight to its result; a tick that keeps its task
// first reads and decrements its counter; a tick that schedules also scans
// the n active slots, and one that needs a reload reloads the counters from
// the priorities and scans again, n being the active slot count; the scans
// read the counter memory one slot per cycle. One item is worked on at a
// time; the next is accepted in the cycle after the result enters the output
// register, even while it waits there.
// Reset: all counters and priorities read zero, the idle slot runs,
// active_tasks is 2. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the sequencer
// still takes the next item, then waits with its result and takes no more.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler #(
    parameter int MAX_TASKS     = cpts_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = cpts_pkg::PRIO_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [cpts_pkg::ACT_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,  // task_index[3:0], priority_req[11:4]
    input  logic [0:0]                 s_tuser,  // kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata   // running_task[3:0], switched[4],
                                                 // reloaded[5], stalled[6]
);
    import cpts_pkg::*;

    req_t req;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    assign req.kind         = s_tuser[0];
    assign req.task_index   = s_tdata[3:0];
    assign req.priority_req = s_tdata[11:4];

    cpts_core #(
        .MAX_TASKS     (MAX_TASKS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register frees as it is taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {1'b0, res.stalled, res.reloaded, res.switched, res.running_task};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
